### src/lus_pkg.sv
// ----------------------------------------------------------------------------
// lus_pkg
// Shared types and codes for the fixed-point LU linear system solver.
// ----------------------------------------------------------------------------
package lus_pkg;

	localparam int LUS_MAX_N     = 16;
	localparam int LUS_FRAC_BITS = 16;
	localparam int LUS_N_LIMIT   = 16;
	localparam int LUS_DATA_W    = 32;

	localparam logic [1:0] ACT_LOAD_MAT = 2'd0;
	localparam logic [1:0] ACT_LOAD_RHS = 2'd1;
	localparam logic [1:0] ACT_SOLVE    = 2'd2;

	// register index as seen on paddr[2]
	localparam logic REG_MATRIX_SIZE = 1'b0;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
	} lus_in_word_t;

	typedef struct packed {
		logic [3:0]         index;
		logic signed [31:0] solution_value;
		logic               last;
		logic               status;
	} lus_out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_RD,
		S_INIT_WAIT,
		S_TERM_RD,
		S_TERM_WAIT,
		S_PROD,
		S_SUB,
		S_FIN,
		S_DIV,
		S_WRITE,
		S_EMIT_RD,
		S_EMIT_WAIT,
		S_EMIT
	} lus_state_t;

	typedef enum logic [2:0] {
		PH_L,
		PH_U,
		PH_Y,
		PH_X,
		PH_E
	} lus_phase_t;

	typedef enum logic [1:0] {
		DIV_INIT,
		DIV_TERM,
		DIV_FIN
	} lus_div_use_t;

endpackage

### src/lus_stream_if.sv
// ----------------------------------------------------------------------------
// lus_stream_if
// Valid/ready channel carrying one word of a packed payload type.
// ----------------------------------------------------------------------------
interface lus_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/lus_ram.sv
// ----------------------------------------------------------------------------
// lus_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lus_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/lu_linear_system_solver.sv
// ----------------------------------------------------------------------------
// lu_linear_system_solver
// Crout LU factorization (unit diagonal in U) with forward and back
// substitution on signed fixed-point values, all matrices and vectors held in RAMs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  load      in   valid/ready          action, row, col, value
//  result    out  valid/ready          index, solution_value, last, status
//  apb       in   psel/penable/pready  matrix_size at byte address 0
//
//  Load words are accepted only while the solver is idle. A solve runs a
//  shared multiplier and one bit-serial divider in turn: each product term
//  is read, multiplied and, in U, divided by the pivot before it is
//  subtracted, so a solve takes about n^3/6 divisions plus n^3/3 products.
//  Each solution word is read, registered and held on result until taken.
//  Reset needs no clearing pass; load is not ready from a solve word until the last solution word is taken.
// ----------------------------------------------------------------------------
module lu_linear_system_solver
	import lus_pkg::*;
#(
	parameter int MAX_N     = LUS_MAX_N,
	parameter int FRAC_BITS = LUS_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	lus_stream_if.sink   load,
	lus_stream_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW     = $clog2(MAX_N);
	localparam int NCAP   = (MAX_N < LUS_N_LIMIT) ? MAX_N : LUS_N_LIMIT;
	localparam int CW     = $clog2(NCAP + 1);
	localparam int MAW    = 2 * IW;
	localparam int MDEPTH = 1 << MAW;
	localparam int VDEPTH = 1 << IW;
	localparam int DW     = LUS_DATA_W + FRAC_BITS;
	localparam int DCW    = $clog2(DW + 1);
	localparam logic [CW-1:0] ONE = CW'(1);

	lus_state_t   state_q, state_d;
	lus_phase_t   phase_q;
	lus_div_use_t div_use_q, div_use_d;

	logic [4:0]    size_q;
	logic [CW-1:0] n_q, i_q, j_q, k_q, k_start, k_end, eff_n;
	logic [IW-1:0] i_ix, j_ix, k_ix;

	logic signed [31:0] acc_q, term_q, piv_q;
	logic signed [63:0] prod_s1, prod_shift;
	logic signed [31:0] prod_sat, mul_a, mul_b, init_data;

	logic               div_start;
	logic signed [31:0] div_dvd, div_dvs;
	logic [31:0]        div_rem_q, div_den_q;
	logic [DW-1:0]      div_quo_q;
	logic               div_neg_q, div_zero_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [32:0]        div_sh;
	logic               div_ge, div_done;
	logic signed [31:0] div_res;

	logic          singular_q, out_valid_q, in_acc, cfg_wr;
	lus_out_word_t out_q;

	logic [MAW-1:0] mat_waddr, mat_raddr, lo_waddr, lo_raddr, up_waddr, up_raddr;
	logic [IW-1:0]  rhs_waddr, fwd_raddr, sol_raddr;
	logic           mat_we, rhs_we, lo_we, up_we, fwd_we, sol_we;
	logic [31:0]    mat_rdata, rhs_rdata, lo_rdata, up_rdata, fwd_rdata, sol_rdata;

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			return d[32] ? Q_MIN : Q_MAX;
		end
		return d[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_MATRIX_SIZE);
	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {27'b0, size_q} : '0;

	always_comb begin
		if (size_q == 5'd0) begin
			eff_n = ONE;
		end else if (32'(size_q) > NCAP) begin
			eff_n = CW'(NCAP);
		end else begin
			eff_n = CW'(size_q);
		end
	end

	// ------------------------------------------------------------------
	// channels
	// ------------------------------------------------------------------
	assign load.ready   = (state_q == S_IDLE);
	assign in_acc       = load.valid & load.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// ------------------------------------------------------------------
	// addressing
	// ------------------------------------------------------------------
	assign i_ix = IW'(i_q);
	assign j_ix = IW'(j_q);
	assign k_ix = IW'(k_q);

	assign k_start = (phase_q == PH_X) ? (i_q + ONE) : '0;
	assign k_end   = (phase_q == PH_X) ? n_q : i_q;

	assign mat_we    = in_acc && (load.data.action == ACT_LOAD_MAT)
		&& (32'(load.data.row) < MAX_N) && (32'(load.data.col) < MAX_N);
	assign mat_waddr = {IW'(load.data.row), IW'(load.data.col)};
	assign rhs_we    = in_acc && (load.data.action == ACT_LOAD_RHS)
		&& (32'(load.data.row) < MAX_N);
	assign rhs_waddr = IW'(load.data.row);

	assign mat_raddr = (phase_q == PH_L) ? {j_ix, i_ix} : {i_ix, j_ix};
	// in forward phase k reaches i at the end, which reads the pivot
	assign lo_raddr  = (phase_q == PH_L) ? {j_ix, k_ix} : {i_ix, k_ix};
	always_comb begin
		case (phase_q)
			PH_L:    up_raddr = {k_ix, i_ix};
			PH_U:    up_raddr = {k_ix, j_ix};
			default: up_raddr = {i_ix, k_ix};
		endcase
	end
	assign fwd_raddr = (phase_q == PH_X) ? i_ix : k_ix;
	assign sol_raddr = (phase_q == PH_X) ? k_ix : i_ix;

	assign lo_we    = (state_q == S_WRITE) && (phase_q == PH_L);
	assign up_we    = (state_q == S_WRITE) && (phase_q == PH_U);
	assign fwd_we   = (state_q == S_WRITE) && (phase_q == PH_Y);
	assign sol_we   = (state_q == S_WRITE) && (phase_q == PH_X);
	assign lo_waddr = {j_ix, i_ix};
	assign up_waddr = {i_ix, j_ix};

	lus_ram #(.W(32), .DEPTH(MDEPTH)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(load.data.value),
		.raddr(mat_raddr), .rdata(mat_rdata));
	lus_ram #(.W(32), .DEPTH(VDEPTH)) u_rhs (
		.clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(load.data.value),
		.raddr(i_ix), .rdata(rhs_rdata));
	lus_ram #(.W(32), .DEPTH(MDEPTH)) u_lo (
		.clk(clk), .we(lo_we), .waddr(lo_waddr), .wdata(acc_q),
		.raddr(lo_raddr), .rdata(lo_rdata));
	lus_ram #(.W(32), .DEPTH(MDEPTH)) u_up (
		.clk(clk), .we(up_we), .waddr(up_waddr), .wdata(acc_q),
		.raddr(up_raddr), .rdata(up_rdata));
	lus_ram #(.W(32), .DEPTH(VDEPTH)) u_fwd (
		.clk(clk), .we(fwd_we), .waddr(i_ix), .wdata(acc_q),
		.raddr(fwd_raddr), .rdata(fwd_rdata));
	lus_ram #(.W(32), .DEPTH(VDEPTH)) u_sol (
		.clk(clk), .we(sol_we), .waddr(i_ix), .wdata(acc_q),
		.raddr(sol_raddr), .rdata(sol_rdata));

	// ------------------------------------------------------------------
	// arithmetic
	// ------------------------------------------------------------------
	always_comb begin
		case (phase_q)
			PH_Y: begin
				mul_a     = lo_rdata;
				mul_b     = fwd_rdata;
				init_data = rhs_rdata;
			end
			PH_X: begin
				mul_a     = up_rdata;
				mul_b     = sol_rdata;
				init_data = fwd_rdata;
			end
			default: begin
				mul_a     = lo_rdata;
				mul_b     = up_rdata;
				init_data = mat_rdata;
			end
		endcase
	end

	// arithmetic shift rounds toward minus infinity
	assign prod_shift = prod_s1 >>> FRAC_BITS;
	assign prod_sat   = ((&prod_shift[63:31]) || !(|prod_shift[63:31]))
		? prod_shift[31:0] : (prod_shift[63] ? Q_MIN : Q_MAX);

	assign div_sh   = {div_rem_q, div_quo_q[DW-1]};
	assign div_ge   = div_sh >= {1'b0, div_den_q};
	assign div_done = (state_q == S_DIV) && (div_zero_q || (div_cnt_q == '0));

	always_comb begin
		if (div_zero_q) begin
			if (div_quo_q == '0) begin
				div_res = '0;
			end else begin
				div_res = div_neg_q ? Q_MIN : Q_MAX;
			end
		end else if (div_neg_q) begin
			div_res = (div_quo_q > {{FRAC_BITS{1'b0}}, 32'h8000_0000})
				? Q_MIN : (~div_quo_q[31:0] + 32'd1);
		end else begin
			div_res = (div_quo_q > {{FRAC_BITS{1'b0}}, 32'h7FFF_FFFF})
				? Q_MAX : div_quo_q[31:0];
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		div_use_d = DIV_INIT;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (load.data.action == ACT_SOLVE)) begin
					state_d = S_INIT_RD;
				end
			end
			S_INIT_RD: state_d = S_INIT_WAIT;
			S_INIT_WAIT: begin
				if (phase_q == PH_U) begin
					div_start = 1'b1;
					div_dvd   = mat_rdata;
					div_dvs   = piv_q;
					div_use_d = DIV_INIT;
					state_d   = S_DIV;
				end else begin
					state_d = S_TERM_RD;
				end
			end
			S_TERM_RD: state_d = (k_q == k_end) ? S_FIN : S_TERM_WAIT;
			S_TERM_WAIT: state_d = S_PROD;
			S_PROD: begin
				if (phase_q == PH_U) begin
					div_start = 1'b1;
					div_dvd   = prod_sat;
					div_dvs   = piv_q;
					div_use_d = DIV_TERM;
					state_d   = S_DIV;
				end else begin
					state_d = S_SUB;
				end
			end
			S_SUB: state_d = S_TERM_RD;
			S_FIN: begin
				if (phase_q == PH_Y) begin
					div_start = 1'b1;
					div_dvd   = acc_q;
					div_dvs   = lo_rdata;
					div_use_d = DIV_FIN;
					state_d   = S_DIV;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					case (div_use_q)
						DIV_INIT: state_d = S_TERM_RD;
						DIV_TERM: state_d = S_SUB;
						default:  state_d = S_WRITE;
					endcase
				end
			end
			S_WRITE: begin
				state_d = ((phase_q == PH_X) && (i_q == '0)) ? S_EMIT_RD : S_INIT_RD;
			end
			S_EMIT_RD:   state_d = S_EMIT_WAIT;
			S_EMIT_WAIT: state_d = S_EMIT;
			S_EMIT: begin
				if (result.ready) begin
					state_d = out_q.last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= 5'd1;
			phase_q     <= PH_L;
			n_q         <= ONE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			singular_q  <= 1'b0;
			out_valid_q <= 1'b0;
			div_use_q   <= DIV_INIT;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_wr) begin
				size_q <= pwdata[4:0];
			end
			if (div_start) begin
				div_use_q <= div_use_d;
				div_cnt_q <= DCW'(DW);
				if (div_dvs == '0) begin
					singular_q <= 1'b1;
				end
			end else if ((state_q == S_DIV) && !div_done) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (load.data.action == ACT_SOLVE)) begin
						phase_q    <= PH_L;
						n_q        <= eff_n;
						i_q        <= '0;
						j_q        <= '0;
						singular_q <= 1'b0;
					end
				end
				S_INIT_WAIT: k_q <= k_start;
				S_SUB:       k_q <= k_q + ONE;
				S_WRITE: begin
					case (phase_q)
						PH_L: begin
							if ((j_q + ONE) < n_q) begin
								j_q <= j_q + ONE;
							end else if ((i_q + ONE) < n_q) begin
								phase_q <= PH_U;
								j_q     <= i_q + ONE;
							end else begin
								phase_q <= PH_Y;
								i_q     <= '0;
							end
						end
						PH_U: begin
							if ((j_q + ONE) < n_q) begin
								j_q <= j_q + ONE;
							end else begin
								phase_q <= PH_L;
								i_q     <= i_q + ONE;
								j_q     <= i_q + ONE;
							end
						end
						PH_Y: begin
							if ((i_q + ONE) < n_q) begin
								i_q <= i_q + ONE;
							end else begin
								phase_q <= PH_X;
								i_q     <= n_q - ONE;
							end
						end
						PH_X: begin
							if (i_q != '0) begin
								i_q <= i_q - ONE;
							end else begin
								phase_q <= PH_E;
							end
						end
						default: ;
					endcase
				end
				S_EMIT_WAIT: out_valid_q <= 1'b1;
				S_EMIT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (!out_q.last) begin
							i_q <= i_q + ONE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_rem_q  <= '0;
			div_den_q  <= mag32(div_dvs);
			div_quo_q  <= DW'(mag32(div_dvd)) << FRAC_BITS;
			div_neg_q  <= div_dvd[31] ^ div_dvs[31];
			div_zero_q <= (div_dvs == '0);
		end
		unique case (state_q)
			S_INIT_WAIT: acc_q   <= init_data;
			S_TERM_WAIT: prod_s1 <= mul_a * mul_b;
			S_PROD:      term_q  <= prod_sat;
			S_SUB:       acc_q   <= sat_sub(acc_q, term_q);
			S_DIV: begin
				if (div_done) begin
					if (div_use_q == DIV_TERM) begin
						term_q <= div_res;
					end else begin
						acc_q <= div_res;
					end
				end else begin
					div_quo_q <= {div_quo_q[DW-2:0], div_ge};
					div_rem_q <= div_ge ? 32'(div_sh - {1'b0, div_den_q}) : div_sh[31:0];
				end
			end
			S_WRITE: begin
				// first word of each L column is the pivot
				if ((phase_q == PH_L) && (j_q == i_q)) begin
					piv_q <= acc_q;
				end
			end
			S_EMIT_WAIT: begin
				out_q.index          <= 4'(i_q);
				out_q.solution_value <= sol_rdata;
				out_q.last           <= (i_q == (n_q - ONE));
				out_q.status         <= singular_q;
			end
			default: ;
		endcase
	end
endmodule

### src/lus_checker.sv
// ----------------------------------------------------------------------------
// lus_checker
// Port-level checks on the solver's channels, bound to the top level.
// ----------------------------------------------------------------------------
module lus_checker
	import lus_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       load_valid,
	input logic       load_ready,
	input logic [1:0] load_action,
	input logic       result_valid,
	input logic       result_ready,
	input logic [3:0] result_index,
	input logic       result_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_index)
			&& $stable(result_last))
		else $error("result word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_ready && result_valid))
		else $error("load ready while a solution word is pending");

	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_valid && load_ready && (load_action == ACT_SOLVE) |=> !load_ready)
		else $error("load still ready after a solve word");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result_last |=> load_ready)
		else $error("not ready after last solution word");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result_last |=> !result_valid)
		else $error("next solution word shown without a fresh read");
endmodule

bind lu_linear_system_solver lus_checker u_lus_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.load_valid   (load.valid),
	.load_ready   (load.ready),
	.load_action  (load.data.action),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_index (result.data.index),
	.result_last  (result.data.last)
);
